// ===== rtl/core/ogne_pkg.sv =====
// Package of the occupancy grid neighbor expander.
// Holds grid constants, step tables, codes, controller types and helper functions.
// Depends on nothing; every other file of the block imports it.
package ogne_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELLS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [9:0] coord_t;
  typedef logic [8:0]        dim_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_EXPAND = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_EXPAND,
    ST_TAIL,
    ST_FINISH
  } state_e;

  localparam logic [1:0] CS_FREE    = 2'd0;
  localparam logic [1:0] CS_BLOCKED = 2'd1;
  localparam logic [1:0] CS_DYNAMIC = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DIAG   = 2'd2;

  localparam logic [1:0] DIR_E = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_N = 2'd3;

  localparam logic [2:0] LAST_CARD = 3'd3;
  localparam logic [2:0] LAST_DIAG = 3'd7;

  localparam logic signed [1:0] STEP_DX [8] = '{
    2'sb01, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb01, 2'sb11, 2'sb11
  };
  localparam logic signed [1:0] STEP_DY [8] = '{
    2'sb00, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb01, 2'sb11
  };

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       write;
    logic       read_cell;
    logic       issue;
    logic [2:0] idx;
    logic       finish;
  } ogne_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic diag_mode;
  } ogne_status_t;

  function automatic dim_t cap_dim(dim_t v, int lim);
    if (int'(v) > lim) begin
      return dim_t'(lim);
    end
    return v;
  endfunction

  function automatic logic in_grid(coord_t x, coord_t y, dim_t cols, dim_t rows);
    return (x >= 0) && (y >= 0) &&
           (x < coord_t'({1'b0, cols})) && (y < coord_t'({1'b0, rows}));
  endfunction

  function automatic addr_t cell_addr(coord_t x, coord_t y);
    return addr_t'(int'(y[8:0]) * MAX_WIDTH + int'(x[8:0]));
  endfunction

endpackage

// ===== rtl/core/ogne_ctrl.sv =====
// Controller of the occupancy grid neighbor expander.
// Sequences clearing, cell writes, reads and neighbor expansion; imports ogne_pkg.
// Drives the datapath through command signals and watches its status.
module ogne_ctrl import ogne_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [1:0]   action_i,
  input  ogne_status_t status_i,
  output ogne_cmd_t    cmd_o,
  output logic         busy_o
);

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       last_step;

  assign last_step = (step_q == (status_i.diag_mode ? LAST_DIAG : LAST_CARD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_d = '0;
        if (start_i) begin
          case (action_e'(action_i))
            ACT_WRITE:  state_d = ST_WRITE;
            ACT_READ:   state_d = ST_READ;
            ACT_EXPAND: state_d = ST_EXPAND;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:     state_d = ST_IDLE;
      ST_READ:      state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_IDLE;
      ST_EXPAND: begin
        step_d = step_q + 3'd1;
        if (last_step) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL:   state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.idx       = step_q;
    cmd_o.load      = (state_q == ST_IDLE) && start_i;
    cmd_o.clear     = (state_q == ST_CLEAR);
    cmd_o.write     = (state_q == ST_WRITE);
    cmd_o.read_cell = (state_q == ST_READ);
    cmd_o.issue     = (state_q == ST_EXPAND);
    cmd_o.finish    = (state_q == ST_FINISH);
    busy_o          = (state_q != ST_IDLE);
  end

endmodule

// ===== rtl/core/ogne_datapath.sv =====
// Datapath of the occupancy grid neighbor expander.
// Holds the configuration registers, the cell store, the neighbor checks and the
// result register; imports ogne_pkg and is steered by ogne_ctrl.
module ogne_datapath import ogne_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ogne_cmd_t    cmd_i,
  output ogne_status_t status_o,
  input  logic         cfg_valid_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  input  logic [7:0]   cell_x_i,
  input  logic [7:0]   cell_y_i,
  input  logic [1:0]   new_state_i,
  output logic         result_valid_o,
  output logic [7:0]   neighbor_x_o,
  output logic [7:0]   neighbor_y_o,
  output logic [1:0]   read_state_o,
  output logic         found_o,
  output logic         last_o
);

  dim_t       width_q, height_q;
  logic       diag_q;
  dim_t       cols, rows;

  logic [7:0] x_q, y_q;
  logic [1:0] ns_q;
  coord_t     cx, cy;

  logic [1:0] mem_q [CELLS];
  logic [1:0] rdata_q;
  addr_t      clr_q;
  addr_t      mem_addr;
  logic       mem_we;
  logic [1:0] mem_wdata;

  coord_t     nx, ny;
  logic       rd_vld_q;
  logic       iss_vld_q, iss_inb_q;
  logic [2:0] iss_idx_q;
  logic [7:0] iss_nx_q, iss_ny_q;

  logic [3:0] card_q;
  logic       pend_vld_q;
  logic [7:0] pend_x_q, pend_y_q;
  logic       open_cell, qualify;

  logic       out_vld_q;
  logic [7:0] out_x_q, out_y_q;
  logic [1:0] out_st_q;
  logic       out_found_q, out_last_q;

  assign cols = cap_dim(width_q, MAX_WIDTH);
  assign rows = cap_dim(height_q, MAX_HEIGHT);
  assign cx   = coord_t'({2'b00, x_q});
  assign cy   = coord_t'({2'b00, y_q});
  assign nx   = cx + coord_t'(STEP_DX[cmd_i.idx]);
  assign ny   = cy + coord_t'(STEP_DY[cmd_i.idx]);

  assign status_o.clear_done = (clr_q == addr_t'(CELLS - 1));
  assign status_o.diag_mode  = diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      diag_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_DIAG:   diag_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= cell_x_i;
      y_q  <= cell_y_i;
      ns_q <= new_state_i;
    end
  end

  always_comb begin
    mem_addr  = cell_addr(cx, cy);
    mem_we    = 1'b0;
    mem_wdata = ns_q;
    if (cmd_i.clear) begin
      mem_addr  = clr_q;
      mem_we    = 1'b1;
      mem_wdata = CS_FREE;
    end else if (cmd_i.write) begin
      mem_we = (ns_q inside {CS_FREE, CS_BLOCKED, CS_DYNAMIC}) && in_grid(cx, cy, cols, rows);
    end else if (cmd_i.issue) begin
      mem_addr = cell_addr(nx, ny);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      iss_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear && !status_o.clear_done) begin
        clr_q <= clr_q + addr_t'(1);
      end
      rd_vld_q  <= cmd_i.read_cell;
      iss_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q <= cmd_i.idx;
    iss_inb_q <= in_grid(nx, ny, cols, rows);
    iss_nx_q  <= nx[7:0];
    iss_ny_q  <= ny[7:0];
  end

  always_comb begin
    open_cell = iss_inb_q && (rdata_q == CS_FREE);
    if (iss_idx_q[2]) begin
      qualify = open_cell && card_q[iss_idx_q[1] ? DIR_W : DIR_E]
                          && card_q[iss_idx_q[0] ? DIR_N : DIR_S];
    end else begin
      qualify = open_cell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= 1'b0;
      if (cmd_i.load) begin
        card_q     <= '0;
        pend_vld_q <= 1'b0;
      end else if (iss_vld_q) begin
        if (!iss_idx_q[2]) begin
          card_q[iss_idx_q[1:0]] <= open_cell;
        end
        if (qualify) begin
          pend_vld_q <= 1'b1;
          out_vld_q  <= pend_vld_q;
        end
      end else if (cmd_i.finish || rd_vld_q) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_vld_q && qualify) begin
      pend_x_q    <= iss_nx_q;
      pend_y_q    <= iss_ny_q;
      out_x_q     <= pend_x_q;
      out_y_q     <= pend_y_q;
      out_st_q    <= CS_FREE;
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      out_x_q     <= pend_vld_q ? pend_x_q : 8'd0;
      out_y_q     <= pend_vld_q ? pend_y_q : 8'd0;
      out_st_q    <= CS_FREE;
      out_found_q <= pend_vld_q;
      out_last_q  <= 1'b1;
    end else if (rd_vld_q) begin
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_st_q    <= in_grid(cx, cy, cols, rows) ? rdata_q : CS_BLOCKED;
      out_found_q <= 1'b0;
      out_last_q  <= 1'b1;
    end
  end

  assign result_valid_o = out_vld_q;
  assign neighbor_x_o   = out_x_q;
  assign neighbor_y_o   = out_y_q;
  assign read_state_o   = out_st_q;
  assign found_o        = out_found_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/core/occupancy_grid_neighbor_expander.sv =====
// Top level of the occupancy grid neighbor expander.
// Joins the controller ogne_ctrl and the datapath ogne_datapath; imports ogne_pkg.
//
// After reset the block clears its cell store one cell per cycle and holds
// busy_o high meanwhile. A command is taken when start_i is high and busy_o is
// low. A write passes through the write state after it is taken, a read through
// a read state and a read wait state with its result following, and an
// expansion through one read of the single-port cell store per neighbor in
// four-connected or eight-connected mode, plus one pipeline stage for the last
// read and a finish state that sends the final result, which follows. Each
// result is shown for exactly one cycle with result_valid_o high and cannot be
// held off; the last result of a transaction carries last_o. Configuration
// writes are always accepted.
module occupancy_grid_neighbor_expander import ogne_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] cell_x_i,
  input  logic [7:0] cell_y_i,
  input  logic [1:0] new_state_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [7:0] neighbor_x_o,
  output logic [7:0] neighbor_y_o,
  output logic [1:0] read_state_o,
  output logic       found_o,
  output logic       last_o
);

  ogne_cmd_t    cmd;
  ogne_status_t status;

  assign cfg_ready_o = 1'b1;

  ogne_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ogne_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .new_state_i    (new_state_i),
    .result_valid_o (result_valid_o),
    .neighbor_x_o   (neighbor_x_o),
    .neighbor_y_o   (neighbor_y_o),
    .read_state_o   (read_state_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for occupancy_grid_neighbor_expander.
// Drives write, read and expand commands against a predictor of the cell grid and its
// neighbor search and checks every result; depends on ogne_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import ogne_pkg::*;

  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [1:0] CS_NONE     = 2'd3;
  localparam logic [1:0] CFG_NONE    = 2'd3;
  localparam int         SETTLE_CYC  = 16;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASES      = 7;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] state;
  } grid_cmd_t;

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [1:0] state;
    logic       found;
    logic       last;
  } grid_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic [1:0] action_i    = 2'd0;
  logic [7:0] cell_x_i    = 8'd0;
  logic [7:0] cell_y_i    = 8'd0;
  logic [1:0] new_state_i = 2'd0;
  logic       cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [8:0] cfg_data_i  = 9'd0;
  logic       busy_o;
  logic       cfg_ready_o;
  logic       result_valid_o;
  logic [7:0] neighbor_x_o;
  logic [7:0] neighbor_y_o;
  logic [1:0] read_state_o;
  logic       found_o;
  logic       last_o;

  grid_cmd_t    pending_cmds [$];
  grid_result_t expected_results [$];
  grid_cmd_t    cmd_on_bus;
  logic [1:0]   grid_cells [MAX_WIDTH*MAX_HEIGHT];
  dim_t         cols_cfg = 9'd256;
  dim_t         rows_cfg = 9'd256;
  logic         diag_cfg = 1'b0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left  = 4;
  int           idle_gap    = 0;

  int phase_w [PHASES] = '{8, 1, 256, 511, 0, 12, 2};
  int phase_h [PHASES] = '{8, 1, 256, 300, 7, 3, 200};
  int phase_d [PHASES] = '{1, 1, 1, 0, 1, 0, 1};
  int phase_n [PHASES] = '{18, 6, 14, 12, 5, 16, 15};

  occupancy_grid_neighbor_expander DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .new_state_i   (new_state_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .neighbor_x_o  (neighbor_x_o),
    .neighbor_y_o  (neighbor_y_o),
    .read_state_o  (read_state_o),
    .found_o       (found_o),
    .last_o        (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int cols_used();
    return (int'(cols_cfg) > MAX_WIDTH) ? MAX_WIDTH : int'(cols_cfg);
  endfunction

  function automatic int rows_used();
    return (int'(rows_cfg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_cfg);
  endfunction

  function automatic bit cell_inside(int x, int y);
    return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
  endfunction

  function automatic logic [1:0] cell_state(int x, int y);
    if (!cell_inside(x, y)) begin
      return CS_BLOCKED;
    end
    return grid_cells[y*MAX_WIDTH + x];
  endfunction

  function automatic bit cell_open(int x, int y);
    return cell_inside(x, y) && cell_state(x, y) == CS_FREE;
  endfunction

  // Applies one accepted command to the grid copy and queues the results it causes.
  function automatic void predict_command(grid_cmd_t cmd);
    int cx;
    int cy;
    int nx;
    int ny;
    int hits;
    int dirs;
    int hit_x [8];
    int hit_y [8];
    cx = int'(cmd.x);
    cy = int'(cmd.y);
    hits = 0;
    dirs = diag_cfg ? 8 : 4;
    case (cmd.action)
      ACT_WRITE: begin
        if (cmd.state != CS_NONE && cell_inside(cx, cy)) begin
          grid_cells[cy*MAX_WIDTH + cx] = cmd.state;
        end
      end
      ACT_READ: begin
        expected_results.insert(expected_results.size(),
                                grid_result_t'{cmd.x, cmd.y, cell_state(cx, cy),
                                               1'b0, 1'b1});
      end
      ACT_EXPAND: begin
        for (int i = 0; i < dirs; i++) begin
          nx = cx + int'(STEP_DX[i]);
          ny = cy + int'(STEP_DY[i]);
          if (cell_open(nx, ny) && (i < 4 || (cell_open(nx, cy) && cell_open(cx, ny)))) begin
            hit_x[hits] = nx;
            hit_y[hits] = ny;
            hits++;
          end
        end
        if (hits == 0) begin
          expected_results.insert(expected_results.size(),
                                  grid_result_t'{8'd0, 8'd0, CS_FREE, 1'b0, 1'b1});
        end
        for (int k = 0; k < hits; k++) begin
          expected_results.insert(expected_results.size(),
                                  grid_result_t'{8'(hit_x[k]), 8'(hit_y[k]), CS_FREE,
                                                 1'b1, k == hits - 1});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom);
    end
    if (span <= 16) begin
      return 8'($urandom_range(0, span));
    end
    if ($urandom_range(0, 1) == 1) begin
      return 8'($urandom_range(0, 9));
    end
    return 8'(span - 1 - $urandom_range(0, 9));
  endfunction

  function automatic grid_cmd_t random_cmd();
    grid_cmd_t cmd;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      cmd.action = ACT_WRITE;
    end else if (roll < 60) begin
      cmd.action = ACT_READ;
    end else if (roll < 97) begin
      cmd.action = ACT_EXPAND;
    end else begin
      cmd.action = ACT_NONE;
    end
    cmd.x = pick_coord(cols_used());
    cmd.y = pick_coord(rows_used());
    cmd.state = ($urandom_range(0, 11) == 0) ? CS_NONE : 2'($urandom_range(0, 2));
    return cmd;
  endfunction

  task automatic queue_cmd(logic [1:0] action, int x, int y, logic [1:0] state);
    pending_cmds.insert(pending_cmds.size(), grid_cmd_t'{action, 8'(x), 8'(y), state});
  endtask

  task automatic report_error(string msg);
    $display("tb_top: %s", msg);
    error_count++;
  endtask

  // Leaves cfg_valid_i high so that back-to-back writes need no extra edge.
  task automatic write_register(logic [1:0] idx, logic [8:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      CFG_WIDTH:  cols_cfg = val;
      CFG_HEIGHT: rows_cfg = val;
      CFG_DIAG:   diag_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int d);
    write_register(CFG_WIDTH, 9'(w));
    write_register(CFG_HEIGHT, 9'(h));
    write_register(CFG_DIAG, 9'(d));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every command is taken and every result has come, then lets
  // trailing writes finish.
  task automatic settle();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || start_i || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_command(cmd_on_bus);
      end
      if (!start_i || !busy_o) begin
        if (idle_gap > 0) begin
          idle_gap--;
          start_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_on_bus = pending_cmds.pop_front();
          action_i    <= cmd_on_bus.action;
          cell_x_i    <= cmd_on_bus.x;
          cell_y_i    <= cmd_on_bus.y;
          new_state_i <= cmd_on_bus.state;
          start_i     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    grid_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result (%0d,%0d) with nothing expected",
                               neighbor_x_o, neighbor_y_o));
      end else begin
        want = expected_results.pop_front();
        if (neighbor_x_o !== want.nx) begin
          report_error($sformatf("neighbor_x %0d, want %0d", neighbor_x_o, want.nx));
        end
        if (neighbor_y_o !== want.ny) begin
          report_error($sformatf("neighbor_y %0d, want %0d", neighbor_y_o, want.ny));
        end
        if (read_state_o !== want.state) begin
          report_error($sformatf("read_state %0d, want %0d", read_state_o, want.state));
        end
        if (found_o !== want.found) begin
          report_error($sformatf("found %0b, want %0b", found_o, want.found));
        end
        if (last_o !== want.last) begin
          report_error($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < MAX_WIDTH*MAX_HEIGHT; k++) begin
      grid_cells[k] = CS_FREE;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full grid, four-connected: corners, blocked and dynamic cells, ignored codes.
    queue_cmd(ACT_EXPAND, 0, 0, CS_FREE);
    queue_cmd(ACT_EXPAND, 255, 255, CS_FREE);
    queue_cmd(ACT_WRITE, 1, 0, CS_BLOCKED);
    queue_cmd(ACT_WRITE, 0, 1, CS_DYNAMIC);
    queue_cmd(ACT_EXPAND, 0, 0, CS_FREE);
    queue_cmd(ACT_READ, 1, 0, CS_FREE);
    queue_cmd(ACT_READ, 0, 1, CS_FREE);
    queue_cmd(ACT_READ, 255, 255, CS_DYNAMIC);
    queue_cmd(ACT_WRITE, 1, 0, CS_NONE);
    queue_cmd(ACT_READ, 1, 0, CS_FREE);
    queue_cmd(ACT_NONE, 255, 255, CS_NONE);
    queue_cmd(ACT_WRITE, 1, 0, CS_FREE);
    queue_cmd(ACT_WRITE, 0, 1, CS_FREE);
    settle();

    // Small grid, eight-connected: outside cells and corner cutting.
    write_register(CFG_NONE, 9'h1FF);
    configure(6, 5, 1);
    queue_cmd(ACT_WRITE, 200, 200, CS_BLOCKED);
    queue_cmd(ACT_READ, 200, 200, CS_FREE);
    queue_cmd(ACT_READ, 5, 4, CS_FREE);
    queue_cmd(ACT_READ, 6, 4, CS_FREE);
    queue_cmd(ACT_EXPAND, 6, 2, CS_FREE);
    queue_cmd(ACT_WRITE, 3, 2, CS_BLOCKED);
    queue_cmd(ACT_EXPAND, 2, 2, CS_FREE);
    queue_cmd(ACT_EXPAND, 5, 4, CS_FREE);
    queue_cmd(ACT_EXPAND, 0, 0, CS_FREE);
    queue_cmd(ACT_WRITE, 3, 2, CS_FREE);
    queue_cmd(ACT_EXPAND, 2, 2, CS_FREE);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_w[p], phase_h[p], phase_d[p]);
      for (int k = 0; k < phase_n[p]; k++) begin
        pending_cmds.insert(pending_cmds.size(), random_cmd());
      end
      settle();
    end

    if (expected_results.size() != 0) begin
      report_error($sformatf("%0d results never came", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== occupancy_grid_neighbor_expander.f =====
rtl/core/ogne_pkg.sv
rtl/core/ogne_ctrl.sv
rtl/core/ogne_datapath.sv
rtl/core/occupancy_grid_neighbor_expander.sv
sim/tb_top.sv
